// ----- rtl/core/sfp_pkg.sv -----
// ----------------------------------------------------------------------------
// Sonar frame parser package
// Shared types and constants for the sonar frame parser core.
// ----------------------------------------------------------------------------
package sfp_pkg;

    localparam int KEPT_BYTES = 5;

    typedef enum logic [3:0] {
        PH_HDR1    = 4'd0,
        PH_HDR2    = 4'd1,
        PH_LEN_L   = 4'd2,
        PH_LEN_H   = 4'd3,
        PH_ID_L    = 4'd4,
        PH_ID_H    = 4'd5,
        PH_SRC     = 4'd6,
        PH_DST     = 4'd7,
        PH_PAYLOAD = 4'd8,
        PH_SUM_L   = 4'd9,
        PH_SUM_H   = 4'd10
    } t_phase;

    typedef enum logic {
        REG_HEADER_FIRST  = 1'b0,
        REG_HEADER_SECOND = 1'b1
    } t_reg_index;

    localparam logic [7:0] HEADER_FIRST_RESET  = 8'd66;
    localparam logic [7:0] HEADER_SECOND_RESET = 8'd82;

    typedef struct packed {
        logic [7:0] header_first;
        logic [7:0] header_second;
    } t_cfg;

    typedef struct packed {
        logic        frame_good;
        logic        checksum_error;
        logic [15:0] message_id;
        logic [31:0] distance_mm;
        logic [7:0]  confidence;
    } t_result;

endpackage

// ----- rtl/core/sfp_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Sonar frame parser configuration registers
// APB-style register file holding the two frame header byte values.
// ----------------------------------------------------------------------------
module sfp_cfg_regs
    import sfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    t_reg_index w_index;
    logic       w_write;

    assign pready  = 1'b1;
    assign w_index = t_reg_index'(paddr[2]);
    assign w_write = psel && penable && pwrite && pready;

    always_comb begin
        n_cfg = r_cfg;
        if (w_write) begin
            case (w_index)
                REG_HEADER_FIRST:  n_cfg.header_first  = pwdata[7:0];
                REG_HEADER_SECOND: n_cfg.header_second = pwdata[7:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_first  <= HEADER_FIRST_RESET;
            r_cfg.header_second <= HEADER_SECOND_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (w_index)
            REG_HEADER_FIRST:  prdata = {24'd0, r_cfg.header_first};
            REG_HEADER_SECOND: prdata = {24'd0, r_cfg.header_second};
            default:           prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/core/sfp_parser.sv -----
// ----------------------------------------------------------------------------
// Sonar frame parser state machine
// Tracks frame phase, length, id, running sum and kept payload bytes, and
// forms the result for the byte being processed.
// ----------------------------------------------------------------------------
module sfp_parser
    import sfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_data_byte,
    input  t_cfg       i_cfg,
    output t_result    o_result
);

    t_phase      r_phase,          n_phase;
    logic [15:0] r_frame_length,   n_frame_length;
    logic [15:0] r_bytes_received, n_bytes_received;
    logic [15:0] r_frame_id,       n_frame_id;
    logic [15:0] r_running_sum,    n_running_sum;
    logic [7:0]  r_sum_low,        n_sum_low;
    logic [7:0]  r_kept [KEPT_BYTES];
    logic [7:0]  n_kept [KEPT_BYTES];
    logic [15:0] w_byte_ext;

    assign w_byte_ext = {8'd0, i_data_byte};

    // Next state.
    always_comb begin
        n_phase          = r_phase;
        n_frame_length   = r_frame_length;
        n_bytes_received = r_bytes_received;
        n_frame_id       = r_frame_id;
        n_running_sum    = r_running_sum;
        n_sum_low        = r_sum_low;
        for (int i = 0; i < KEPT_BYTES; i++) begin
            n_kept[i] = r_kept[i];
        end
        case (r_phase)
            PH_HDR2: begin
                if (i_data_byte == i_cfg.header_second) begin
                    n_running_sum = r_running_sum + {8'd0, i_cfg.header_second};
                    n_phase       = PH_LEN_L;
                end else begin
                    n_phase = PH_HDR1;
                end
            end
            PH_LEN_L: begin
                n_frame_length = w_byte_ext;
                n_running_sum  = r_running_sum + w_byte_ext;
                n_phase        = PH_LEN_H;
            end
            PH_LEN_H: begin
                n_frame_length   = {i_data_byte, r_frame_length[7:0]};
                n_bytes_received = 16'd0;
                n_running_sum    = r_running_sum + w_byte_ext;
                n_phase          = PH_ID_L;
            end
            PH_ID_L: begin
                n_frame_id    = w_byte_ext;
                n_running_sum = r_running_sum + w_byte_ext;
                n_phase       = PH_ID_H;
            end
            PH_ID_H: begin
                n_frame_id    = {i_data_byte, r_frame_id[7:0]};
                n_running_sum = r_running_sum + w_byte_ext;
                n_phase       = PH_SRC;
            end
            PH_SRC: begin
                n_running_sum = r_running_sum + w_byte_ext;
                n_phase       = PH_DST;
            end
            PH_DST: begin
                n_running_sum = r_running_sum + w_byte_ext;
                // An empty payload goes straight to the checksum bytes.
                n_phase = (r_frame_length == 16'd0) ? PH_SUM_L : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                for (int i = 0; i < KEPT_BYTES; i++) begin
                    if (r_bytes_received == 16'(i)) begin
                        n_kept[i] = i_data_byte;
                    end
                end
                n_bytes_received = r_bytes_received + 16'd1;
                n_running_sum    = r_running_sum + w_byte_ext;
                if (n_bytes_received >= r_frame_length) begin
                    n_phase = PH_SUM_L;
                end
            end
            PH_SUM_L: begin
                n_sum_low = i_data_byte;
                n_phase   = PH_SUM_H;
            end
            PH_SUM_H: begin
                n_phase = PH_HDR1;
            end
            default: begin
                n_phase = PH_HDR1;
                if (i_data_byte == i_cfg.header_first) begin
                    n_running_sum = {8'd0, i_cfg.header_first};
                    n_phase       = PH_HDR2;
                end
            end
        endcase
    end

    // Result for the byte being processed.
    always_comb begin
        o_result.frame_good     = 1'b0;
        o_result.checksum_error = 1'b0;
        if (r_phase == PH_SUM_H) begin
            if ({i_data_byte, r_sum_low} == r_running_sum) begin
                o_result.frame_good = 1'b1;
            end else begin
                o_result.checksum_error = 1'b1;
            end
        end
        o_result.message_id  = n_frame_id;
        o_result.distance_mm = {n_kept[3], n_kept[2], n_kept[1], n_kept[0]};
        o_result.confidence  = n_kept[4];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_HDR1;
            r_frame_length   <= 16'd0;
            r_bytes_received <= 16'd0;
            r_frame_id       <= 16'd0;
            r_running_sum    <= 16'd0;
            r_sum_low        <= 8'd0;
            for (int i = 0; i < KEPT_BYTES; i++) begin
                r_kept[i] <= 8'd0;
            end
        end else if (i_step) begin
            r_phase          <= n_phase;
            r_frame_length   <= n_frame_length;
            r_bytes_received <= n_bytes_received;
            r_frame_id       <= n_frame_id;
            r_running_sum    <= n_running_sum;
            r_sum_low        <= n_sum_low;
            for (int i = 0; i < KEPT_BYTES; i++) begin
                r_kept[i] <= n_kept[i];
            end
        end
    end

endmodule

// ----- rtl/core/sonar_frame_parser_core.sv -----
// ----------------------------------------------------------------------------
// Sonar frame parser core
// Byte-stream tracker for a length-prefixed sonar frame with additive checksum.
// ----------------------------------------------------------------------------
// One received byte per request goes in and one result comes out for each
// byte. A byte is held in an input register, processed by the parser and
// lands in an output register; the core sustains one byte per clock while
// the output is not stalled. The rate rests on the parser updating its state
// (phase, length, 16-bit running sum) once per byte. frame_good or
// checksum_error pulses only on the last checksum byte; message_id,
// distance_mm and confidence show the parser's kept values after each byte.
// Header byte values are to be set through the APB port (header_first at
// 0x0, header_second at 0x4) only while idle; the core does not enforce it.
module sonar_frame_parser_core
    import sfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_frame_good,
    output logic        o_checksum_error,
    output logic [15:0] o_message_id,
    output logic [31:0] o_distance_mm,
    output logic [7:0]  o_confidence
);

    t_cfg       w_cfg;
    t_result    w_result;
    t_result    r_result;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    logic       w_step;
    logic       w_accept;

    sfp_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // The held byte is processed whenever the output register can take it.
    assign w_step     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_step;
    assign w_accept   = i_in_valid && !o_in_stall;

    sfp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_data_byte (r_in_byte),
        .i_cfg       (w_cfg),
        .o_result    (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_frame_good     = r_result.frame_good;
    assign o_checksum_error = r_result.checksum_error;
    assign o_message_id     = r_result.message_id;
    assign o_distance_mm    = r_result.distance_mm;
    assign o_confidence     = r_result.confidence;

endmodule
